// ===== rtl/json_string_unescape_utf8_unit_assert.svh =====
// assertion macros used by the string decoder result register
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define JSU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication, checked out of reset
`define JSU_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/jsu_pkg.sv =====
// types, codes and helper functions of the json string decoder
package jsu_pkg;

  // decoder modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_STR     = 3'd1;
  localparam logic [2:0] MODE_ESC     = 3'd2;
  localparam logic [2:0] MODE_HEX_HI  = 3'd3;
  localparam logic [2:0] MODE_PAIR_BS = 3'd4;
  localparam logic [2:0] MODE_PAIR_U  = 3'd5;
  localparam logic [2:0] MODE_HEX_LO  = 3'd6;

  // error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE   = 4'd1;
  localparam logic [3:0] ERR_BAD_ESC    = 4'd2;
  localparam logic [3:0] ERR_BAD_HEX    = 4'd3;
  localparam logic [3:0] ERR_TRUNC      = 4'd4;
  localparam logic [3:0] ERR_UNP_HIGH   = 4'd5;
  localparam logic [3:0] ERR_BAD_LOW    = 4'd6;
  localparam logic [3:0] ERR_UNP_LOW    = 4'd7;
  localparam logic [3:0] ERR_UNTERM     = 4'd8;

  // characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // control bytes produced by escapes
  localparam logic [7:0] BS_CODE = 8'h08;
  localparam logic [7:0] FF_CODE = 8'h0C;
  localparam logic [7:0] LF_CODE = 8'h0A;
  localparam logic [7:0] CR_CODE = 8'h0D;
  localparam logic [7:0] HT_CODE = 8'h09;

  // surrogate classes by the top six bits of a code unit
  localparam logic [5:0] SUR_HIGH = 6'b110110;
  localparam logic [5:0] SUR_LOW  = 6'b110111;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam int unsigned MAX_RES = 5;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
    logic [3:0] err;
  } res_t;

  // all results caused by one input item
  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [2:0]         cnt;
  } res_list_t;

  // utf-8 encoding of one code point
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } utf8_t;

  // hex digit value, with ok flag in the top bit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // code point to 1..4 utf-8 bytes
  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp < 21'h80) begin
      u.n    = 3'd1;
      u.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      u.n    = 3'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      u.n    = 3'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.n    = 3'd4;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

// ===== rtl/jsu_decode.sv =====
// decoder state and the per-item decode logic producing the result list
module jsu_decode import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output res_list_t  list_o
);

  logic [2:0]  mode_q, mode_d;
  logic [15:0] unit_q, unit_d;
  logic [1:0]  dcnt_q, dcnt_d;
  logic [9:0]  high_q, high_d;
  logic        bad_q, bad_d;

  logic [4:0]  hv;
  logic [15:0] unit_nx;
  logic        bad_nx;
  logic        full;
  logic [1:0]  dcnt_nx;
  logic [3:0]  err;
  logic        done;
  logic        term;
  logic [2:0]  dn;
  logic [3:0][7:0] db;
  utf8_t       enc;

  // hex digit gathering shared by both escapes
  always_comb begin
    hv      = hex_value(in_byte_i);
    bad_nx  = bad_q | ~hv[4];
    unit_nx = hv[4] ? {unit_q[11:0], hv[3:0]} : unit_q;
    full    = (dcnt_q == 2'd3);
    dcnt_nx = full ? dcnt_q : dcnt_q + 2'd1;
  end

  // next state and data bytes
  always_comb begin
    mode_d = mode_q;
    unit_d = unit_q;
    dcnt_d = dcnt_q;
    high_d = high_q;
    bad_d  = bad_q;
    err    = ERR_NONE;
    done   = 1'b0;
    dn     = 3'd0;
    db     = '0;
    enc    = '0;
    case (mode_q)
      MODE_IDLE: begin
        if (in_byte_i == CH_QUOTE) mode_d = MODE_STR;
        else err = ERR_NO_QUOTE;
      end
      MODE_STR: begin
        if (in_byte_i == CH_QUOTE) begin
          done = 1'b1;
        end else if (in_byte_i == CH_BSLASH) begin
          mode_d = MODE_ESC;
        end else begin
          dn    = 3'd1;
          db[0] = in_byte_i;
        end
      end
      MODE_ESC: begin
        mode_d = MODE_STR;
        dn     = 3'd1;
        case (in_byte_i)
          CH_QUOTE, CH_BSLASH, CH_SLASH: db[0] = in_byte_i;
          CH_B: db[0] = BS_CODE;
          CH_F: db[0] = FF_CODE;
          CH_N: db[0] = LF_CODE;
          CH_R: db[0] = CR_CODE;
          CH_T: db[0] = HT_CODE;
          CH_U: begin
            dn     = 3'd0;
            mode_d = MODE_HEX_HI;
            unit_d = '0;
            dcnt_d = '0;
            bad_d  = 1'b0;
            if (end_of_text_i) err = ERR_TRUNC;
          end
          default: begin
            dn  = 3'd0;
            err = ERR_BAD_ESC;
          end
        endcase
      end
      MODE_HEX_HI: begin
        unit_d = unit_nx;
        bad_d  = bad_nx;
        dcnt_d = dcnt_nx;
        if (!full) begin
          if (end_of_text_i) err = ERR_TRUNC;
        end else if (bad_nx) begin
          err = ERR_BAD_HEX;
        end else if (unit_nx[15:10] == SUR_HIGH) begin
          high_d = unit_nx[9:0];
          mode_d = MODE_PAIR_BS;
          if (end_of_text_i) err = ERR_UNP_HIGH;
        end else if (unit_nx[15:10] == SUR_LOW) begin
          err = ERR_UNP_LOW;
        end else begin
          enc    = utf8_encode({5'd0, unit_nx});
          dn     = enc.n;
          db     = enc.b;
          mode_d = MODE_STR;
        end
      end
      MODE_PAIR_BS: begin
        if (in_byte_i != CH_BSLASH || end_of_text_i) err = ERR_UNP_HIGH;
        else mode_d = MODE_PAIR_U;
      end
      MODE_PAIR_U: begin
        if (in_byte_i != CH_U) begin
          err = ERR_UNP_HIGH;
        end else begin
          mode_d = MODE_HEX_LO;
          unit_d = '0;
          dcnt_d = '0;
          bad_d  = 1'b0;
          if (end_of_text_i) err = ERR_TRUNC;
        end
      end
      MODE_HEX_LO: begin
        unit_d = unit_nx;
        bad_d  = bad_nx;
        dcnt_d = dcnt_nx;
        if (!full) begin
          if (end_of_text_i) err = ERR_TRUNC;
        end else if (bad_nx) begin
          err = ERR_BAD_HEX;
        end else if (unit_nx[15:10] == SUR_LOW) begin
          enc    = utf8_encode(SUPP_BASE + {1'b0, high_q, unit_nx[9:0]});
          dn     = enc.n;
          db     = enc.b;
          mode_d = MODE_STR;
        end else begin
          err = ERR_BAD_LOW;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase

    // text ended while still inside the string
    if (err == ERR_NONE && !done && end_of_text_i && mode_d != MODE_IDLE &&
        mode_q <= MODE_HEX_LO) begin
      err = ERR_UNTERM;
    end

    // done or error returns everything to reset
    if (done || err != ERR_NONE) begin
      mode_d = MODE_IDLE;
      unit_d = '0;
      dcnt_d = '0;
      high_d = '0;
      bad_d  = 1'b0;
    end
  end

  // assemble result list: data bytes then, on done or error, one closing entry
  always_comb begin
    term        = done | (err != ERR_NONE);
    list_o.cnt  = dn + {2'b00, term};
    for (int i = 0; i < MAX_RES; i++) begin
      list_o.ent[i] = '0;
      if (3'(i) < dn) begin
        list_o.ent[i].data  = db[i[1:0]];
        list_o.ent[i].valid = 1'b1;
      end else if (3'(i) == dn && term) begin
        list_o.ent[i].done = done;
        list_o.ent[i].err  = err;
      end
    end
  end

  // decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      unit_q <= '0;
      dcnt_q <= '0;
      high_q <= '0;
      bad_q  <= 1'b0;
    end else if (take_i) begin
      mode_q <= mode_d;
      unit_q <= unit_d;
      dcnt_q <= dcnt_d;
      high_q <= high_d;
      bad_q  <= bad_d;
    end
  end

endmodule

// ===== rtl/jsu_outbuf.sv =====
// result register holding up to five results of one item, shifted out one per cycle while the output is ready
module jsu_outbuf import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  res_list_t  list_i,
  output logic       load_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       res_o,
  output logic       last_o
);

  `include "json_string_unescape_utf8_unit_assert.svh"

  res_t [MAX_RES-1:0] ent_q, ent_d;
  logic [2:0]         cnt_q, cnt_d;
  logic               pop;

  // a new item may enter once the final pending result leaves
  assign out_valid_o = (cnt_q != 3'd0);
  assign pop         = out_valid_o & out_ready_i;
  assign in_ready_o  = (cnt_q == 3'd0) | ((cnt_q == 3'd1) & out_ready_i);
  assign load_o      = in_valid_i & in_ready_o;
  assign res_o       = ent_q[0];
  assign last_o      = (cnt_q == 3'd1);

  // load or shift the result entries
  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_o) begin
      ent_d = list_i.ent;
      cnt_d = list_i.cnt;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) ent_d[i] = ent_q[i+1];
      ent_d[MAX_RES-1] = '0;
      cnt_d = cnt_q - 3'd1;
    end
  end

  // payload entries need no reset
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // checks
  `JSU_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= 3'(MAX_RES))
  `JSU_ASSERT_IMP(a_ready_only_last, in_ready_o && out_valid_o, last_o && out_ready_i)
  `JSU_ASSERT_NXT(a_load_shows, load_o && list_i.cnt != 3'd0, out_valid_o)
  `JSU_ASSERT_NXT(a_pop_keeps_rest, pop && !last_o, out_valid_o && cnt_q == $past(cnt_q) - 3'd1)
  `JSU_ASSERT_IMP(a_closing_is_last, out_valid_o && (res_o.done || res_o.err != ERR_NONE), last_o)

endmodule

// ===== rtl/json_string_unescape_utf8_unit.sv =====
// top level of the json string decoder: decode logic and result register
// latency: results of an item appear the cycle after it is accepted
// throughput: one item per cycle if items yield at most one result and output is ready
// an item yielding more than one result holds the input until its last result is taken
// items yielding no result never hold off the next item; async active-low reset returns to idle
module json_string_unescape_utf8_unit import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       string_done_o,
  output logic [3:0] error_code_o,
  output logic       last_o
);

  res_list_t list;
  res_t      res;
  logic      load;

  // per-item decode
  jsu_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (load),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .list_o        (list)
  );

  // result register and serializer
  jsu_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .list_i      (list),
    .load_o      (load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .last_o      (last_o)
  );

  assign out_byte_o    = res.data;
  assign byte_valid_o  = res.valid;
  assign string_done_o = res.done;
  assign error_code_o  = res.err;

endmodule
